@@ rtl/core/csem_pkg.sv @@
// Shared types and constants for the charge session energy monitor.
// Sample/result payload structs, register indexes and reset values.
// No dependencies; compile first.
package csem_pkg;

	// Configuration port geometry
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 48;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CURRENT_FLOOR = 3'd0,
		CFG_LOW_VOLTAGE   = 3'd1,
		CFG_OVER_CURRENT  = 3'd2,
		CFG_FULL_CURRENT  = 3'd3,
		CFG_WINDOW_LEN    = 3'd4,
		CFG_ENERGY_LIMIT  = 3'd5
	} cfg_idx_t;

	// Register reset values
	localparam logic [15:0] RST_CURRENT_FLOOR = 16'd150;
	localparam logic [15:0] RST_LOW_VOLTAGE   = 16'd18000;
	localparam logic [15:0] RST_OVER_CURRENT  = 16'd16000;
	localparam logic [15:0] RST_FULL_CURRENT  = 16'd500;
	localparam logic [7:0]  RST_WINDOW_LEN    = 8'd15;
	localparam logic [47:0] RST_ENERGY_LIMIT  = 48'd0;

	// Window current sum
	localparam int unsigned      SUM_W   = 24;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam int unsigned      LEN_W   = 8;

	// One metering sample
	typedef struct packed {
		logic [15:0] voltage_cv;
		logic [15:0] current_ma;
		logic        session_active;
	} sample_t;

	// One result
	typedef struct packed {
		logic [15:0] current_used;
		logic [31:0] power_raw;
		logic [47:0] energy_now;
		logic        overload;
		logic        battery_full;
		logic        session_timeout;
		logic        counted;
	} result_t;

endpackage

@@ rtl/core/csem_stream_if.sv @@
// Valid/ready stream channel used for samples and results.
// Payload type is a parameter; types come from csem_pkg.
interface csem_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/charge_session_energy_monitor.sv @@
// A sample transaction passes the input reg, multiply reg and result reg before its result is valid.
// Throughput: one sample per cycle; stalls only on result back-pressure.
// State (energy, window sum/count, flags) updates as a result is loaded, in sample order.
// Reset (arst_n low): pipeline empty, state cleared, registers to defaults.
// Depends on csem_pkg and csem_stream_if.
module charge_session_energy_monitor #(
	parameter int unsigned WINDOW_MAX  = 255,
	parameter int unsigned ENERGY_BITS = 48
) (
	input  logic                               clk,
	input  logic                               arst_n,
	csem_stream_if.sink                        smp,
	csem_stream_if.source                      res,
	input  logic                               cfg_we,
	input  logic [csem_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [csem_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int unsigned EW        = ENERGY_BITS;
	localparam int unsigned CMP_W     = (EW > 48) ? EW : 48;
	localparam int unsigned WIN_CAP_I = (WINDOW_MAX < 255) ? WINDOW_MAX : 255;
	localparam logic [csem_pkg::LEN_W-1:0] WIN_CAP = WIN_CAP_I[csem_pkg::LEN_W-1:0];
	localparam logic [EW-1:0] E_MAX = '1;

	// Configuration registers
	logic [15:0] current_floor_q, low_voltage_q, over_current_q, full_current_q;
	logic [7:0]  window_len_q;
	logic [47:0] energy_limit_q;

	// Session state
	logic [EW-1:0]                  energy_q;
	logic [csem_pkg::SUM_W-1:0]     sum_q;
	logic [csem_pkg::LEN_W-1:0]     cnt_q;
	logic                           ovl_q, full_q, tmo_q;

	// Pipeline
	logic        valid_s1, act_s1;
	logic [15:0] volt_s1, cur_s1;
	logic        valid_s2, act_s2;
	logic [15:0] volt_s2, cur_s2;
	logic [31:0] power_s2;
	logic                res_valid_s3;
	csem_pkg::result_t   res_data_s3;

	logic adv1, adv2, load3;
	logic [15:0] cur_clip;

	// Stage 2 datapath
	logic                          counted;
	logic [csem_pkg::LEN_W-1:0]    len;
	logic [EW:0]                   e_sum;
	logic [EW-1:0]                 e_add;
	logic [csem_pkg::SUM_W:0]      s_sum;
	logic [csem_pkg::SUM_W-1:0]    s_add;
	logic [csem_pkg::LEN_W:0]      cnt_inc;
	logic                          wrap;
	logic [csem_pkg::SUM_W-1:0]    full_lim;
	logic                          hit_limit;
	logic [EW-1:0]                 energy_nx;
	logic [csem_pkg::SUM_W-1:0]    sum_nx;
	logic [csem_pkg::LEN_W-1:0]    cnt_nx;
	logic                          ovl_nx, full_nx, tmo_nx;
	logic [CMP_W-1:0]              e_ext;
	csem_pkg::result_t             res_nx;

	// Write configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_floor_q <= csem_pkg::RST_CURRENT_FLOOR;
			low_voltage_q   <= csem_pkg::RST_LOW_VOLTAGE;
			over_current_q  <= csem_pkg::RST_OVER_CURRENT;
			full_current_q  <= csem_pkg::RST_FULL_CURRENT;
			window_len_q    <= csem_pkg::RST_WINDOW_LEN;
			energy_limit_q  <= csem_pkg::RST_ENERGY_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				csem_pkg::CFG_CURRENT_FLOOR: current_floor_q <= cfg_wdata[15:0];
				csem_pkg::CFG_LOW_VOLTAGE:   low_voltage_q   <= cfg_wdata[15:0];
				csem_pkg::CFG_OVER_CURRENT:  over_current_q  <= cfg_wdata[15:0];
				csem_pkg::CFG_FULL_CURRENT:  full_current_q  <= cfg_wdata[15:0];
				csem_pkg::CFG_WINDOW_LEN:    window_len_q    <= cfg_wdata[7:0];
				csem_pkg::CFG_ENERGY_LIMIT:  energy_limit_q  <= cfg_wdata[47:0];
				default: ;
			endcase
		end
	end

	// Handshake: each stage moves when the one after it has room
	assign load3     = valid_s2 && (!res_valid_s3 || res.ready);
	assign adv2      = !valid_s2 || load3;
	assign adv1      = !valid_s1 || adv2;
	assign smp.ready = adv1;

	// Stage 1: capture the sample transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= smp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && smp.valid) begin
			volt_s1 <= smp.data.voltage_cv;
			cur_s1  <= smp.data.current_ma;
			act_s1  <= smp.data.session_active;
		end
	end

	// Clip current below the floor
	assign cur_clip = (cur_s1 < current_floor_q) ? 16'd0 : cur_s1;

	// Stage 2: register clipped current and power
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			volt_s2  <= volt_s1;
			cur_s2   <= cur_clip;
			act_s2   <= act_s1;
			power_s2 <= 32'(volt_s1) * 32'(cur_clip);
		end
	end

	// Accumulate energy and window sum, evaluate limits
	always_comb begin
		counted = act_s2 && !full_q && !ovl_q && !tmo_q;

		len = (window_len_q == '0) ? csem_pkg::LEN_W'(1) : window_len_q;
		if (len > WIN_CAP) begin
			len = WIN_CAP;
		end

		e_sum = {1'b0, energy_q} + (EW+1)'(power_s2);
		e_add = e_sum[EW] ? E_MAX : e_sum[EW-1:0];

		s_sum = {1'b0, sum_q} + (csem_pkg::SUM_W+1)'(cur_s2);
		s_add = s_sum[csem_pkg::SUM_W] ? csem_pkg::SUM_MAX : s_sum[csem_pkg::SUM_W-1:0];

		cnt_inc  = {1'b0, cnt_q} + (csem_pkg::LEN_W+1)'(1);
		wrap     = cnt_inc >= {1'b0, len};
		full_lim = csem_pkg::SUM_W'(full_current_q) * csem_pkg::SUM_W'(len);

		e_ext     = CMP_W'(e_add);
		hit_limit = (e_add != '0) && (e_ext >= CMP_W'(energy_limit_q));

		energy_nx = energy_q;
		sum_nx    = sum_q;
		cnt_nx    = cnt_q;
		ovl_nx    = ovl_q;
		full_nx   = full_q;
		tmo_nx    = tmo_q;
		if (counted) begin
			energy_nx = hit_limit ? '0 : e_add;
			tmo_nx    = hit_limit;
			if (wrap) begin
				full_nx = s_add < full_lim;
				sum_nx  = '0;
				cnt_nx  = '0;
			end else begin
				sum_nx  = s_add;
				cnt_nx  = cnt_inc[csem_pkg::LEN_W-1:0];
			end
			ovl_nx = (volt_s2 < low_voltage_q) || (cur_s2 > over_current_q);
		end

		res_nx.current_used    = cur_s2;
		res_nx.power_raw       = power_s2;
		res_nx.energy_now      = 48'(CMP_W'(energy_nx));
		res_nx.overload        = ovl_nx;
		res_nx.battery_full    = full_nx;
		res_nx.session_timeout = tmo_nx;
		res_nx.counted         = counted;
	end

	// Commit session state as the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			sum_q    <= '0;
			cnt_q    <= '0;
			ovl_q    <= 1'b0;
			full_q   <= 1'b0;
			tmo_q    <= 1'b0;
		end else if (load3) begin
			energy_q <= energy_nx;
			sum_q    <= sum_nx;
			cnt_q    <= cnt_nx;
			ovl_q    <= ovl_nx;
			full_q   <= full_nx;
			tmo_q    <= tmo_nx;
		end
	end

	// Stage 3: result register, held until the result transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s3 <= 1'b0;
		end else if (load3) begin
			res_valid_s3 <= 1'b1;
		end else if (res.ready) begin
			res_valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load3) begin
			res_data_s3 <= res_nx;
		end
	end

	assign res.valid = res_valid_s3;
	assign res.data  = res_data_s3;

endmodule

@@ rtl/core/csem_checker.sv @@
// Port-level checks on the charge session energy monitor result stream.
// Depends on csem_pkg; bound to charge_session_energy_monitor below.
module csem_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input csem_pkg::result_t out_data
);

	logic        out_acc;
	logic        any_flag_q;
	logic        ovl_seen_q;
	logic [47:0] last_energy_q;

	assign out_acc = out_valid && out_ready;

	// Track what the previous result transaction reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_flag_q    <= 1'b0;
			ovl_seen_q    <= 1'b0;
			last_energy_q <= '0;
		end else if (out_acc) begin
			any_flag_q    <= out_data.overload || out_data.battery_full ||
				out_data.session_timeout;
			ovl_seen_q    <= ovl_seen_q || out_data.overload;
			last_energy_q <= out_data.energy_now;
		end
	end

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result changed while stalled");

	// Any latched flag stops counting
	a_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && any_flag_q) |-> !out_data.counted)
		else $error("sample counted while a flag was set");

	// Overload latches until reset
	a_ovl_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && ovl_seen_q) |-> out_data.overload)
		else $error("overload flag cleared");

	// An uncounted sample leaves energy alone
	a_energy_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !out_data.counted) |-> (out_data.energy_now == last_energy_q))
		else $error("energy changed on uncounted sample");

	// Clipped current of zero gives zero power
	a_zero_power: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && (out_data.current_used == '0)) |-> (out_data.power_raw == '0))
		else $error("nonzero power with zero current");

endmodule

bind charge_session_energy_monitor csem_checker u_csem_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_data  (res.data)
);

@@ tb/charge_session_energy_monitor_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for charge_session_energy_monitor: random and directed samples,
// an in-bench predictor of clipping, power, energy and the latching monitors.
// Depends on csem_pkg, csem_stream_if and the block's RTL.
module charge_session_energy_monitor_test;

	localparam int unsigned WINDOW_MAX  = 255;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam logic [csem_pkg::CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
	localparam logic [csem_pkg::CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;
	localparam logic [47:0] ENERGY_FULL_SCALE = '1;

	// Which monitor the closing trial trips
	typedef enum int {
		TRIAL_FULL,
		TRIAL_UNDERVOLT,
		TRIAL_OVERCURRENT,
		TRIAL_LIMIT,
		TRIAL_ZERO_LIMIT
	} trial_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [csem_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [csem_pkg::CFG_DATA_W-1:0] cfg_wdata;

	csem_stream_if #(.T(csem_pkg::sample_t)) smp_if ();
	csem_stream_if #(.T(csem_pkg::result_t)) res_if ();

	charge_session_energy_monitor #(
		.WINDOW_MAX  (WINDOW_MAX),
		.ENERGY_BITS (48)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp       (smp_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor copy of the registers
	logic [15:0] reg_floor, reg_low_v, reg_over_i, reg_full_i;
	logic [7:0]  reg_window;
	logic [47:0] reg_limit;

	// Predictor copy of the metering state
	logic [47:0] energy_acc;
	logic [23:0] window_sum;
	logic [7:0]  window_cnt;
	logic        overload_q, full_q, timeout_q;

	csem_pkg::sample_t pending_samples[$];
	csem_pkg::result_t expected_readings[$];
	csem_pkg::result_t want, got;

	bit     smp_taken;
	bit     tx_idle_on, rx_idle_on;
	int     tx_gap, rx_gap, hold_left, hold_request;
	int     samples_metered, readings_checked, counted_readings, mismatch_count;
	int     config_settings, cycle_count;
	trial_t trial_kind;

	// Clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Work out the reading for one sample and advance the metering state
	function automatic csem_pkg::result_t meter_sample(csem_pkg::sample_t s);
		csem_pkg::result_t r;
		logic [15:0] i_used;
		logic [31:0] p;
		logic        cnt;
		logic [8:0]  len;
		logic [48:0] e_sum;
		logic [24:0] s_sum;
		i_used = (s.current_ma < reg_floor) ? 16'd0 : s.current_ma;
		p = 32'(s.voltage_cv) * 32'(i_used);
		cnt = s.session_active && !full_q && !overload_q && !timeout_q;
		if (cnt) begin
			len = (reg_window == 8'd0) ? 9'd1 : {1'b0, reg_window};
			if (len > 9'(WINDOW_MAX))
				len = 9'(WINDOW_MAX);
			e_sum = {1'b0, energy_acc} + 49'(p);
			energy_acc = e_sum[48] ? ENERGY_FULL_SCALE : e_sum[47:0];
			s_sum = {1'b0, window_sum} + 25'(i_used);
			window_sum = s_sum[24] ? csem_pkg::SUM_MAX : s_sum[23:0];
			window_cnt = window_cnt + 8'd1;
			if (window_cnt >= len) begin
				full_q = ({8'd0, window_sum} < 32'(reg_full_i) * 32'(len));
				window_sum = '0;
				window_cnt = '0;
			end
			if (energy_acc != 48'd0 && energy_acc >= reg_limit) begin
				timeout_q = 1'b1;
				energy_acc = '0;
			end else begin
				timeout_q = 1'b0;
			end
			overload_q = (s.voltage_cv < reg_low_v) || (i_used > reg_over_i);
		end
		r.current_used    = i_used;
		r.power_raw       = p;
		r.energy_now      = energy_acc;
		r.overload        = overload_q;
		r.battery_full    = full_q;
		r.session_timeout = timeout_q;
		r.counted         = cnt;
		return r;
	endfunction

	// Scoreboard: predict on each accepted sample, check each accepted result
	always @(posedge clk) begin
		smp_taken = (arst_n === 1'b1) && smp_if.valid && smp_if.ready;
		if (smp_taken) begin
			expected_readings.push_back(meter_sample(smp_if.data));
			samples_metered++;
		end
		if ((arst_n === 1'b1) && res_if.valid && res_if.ready) begin
			got = res_if.data;
			if (expected_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result with no sample outstanding: cur=%0d pwr=%0d energy=%0d",
						got.current_used, got.power_raw, got.energy_now);
			end else begin
				want = expected_readings.pop_front();
				if (want.counted)
					counted_readings++;
				if (!((got.current_used === want.current_used) &&
						(got.power_raw === want.power_raw) &&
						(got.energy_now === want.energy_now) &&
						(got.overload === want.overload) &&
						(got.battery_full === want.battery_full) &&
						(got.session_timeout === want.session_timeout) &&
						(got.counted === want.counted))) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch on result %0d: ", readings_checked,
							"want cur=%0d pwr=%0d energy=%0d ovl=%b full=%b tmo=%b cnt=%b; ",
							want.current_used, want.power_raw, want.energy_now, want.overload,
							want.battery_full, want.session_timeout, want.counted,
							"got cur=%0d pwr=%0d energy=%0d ovl=%b full=%b tmo=%b cnt=%b",
							got.current_used, got.power_raw, got.energy_now, got.overload,
							got.battery_full, got.session_timeout, got.counted);
				end
			end
			readings_checked++;
		end
	end

	// Sample driver: hold an offered transaction, otherwise idle or present the next one
	always @(negedge clk) begin
		if (arst_n !== 1'b1) begin
			smp_if.valid <= 1'b0;
		end else if (smp_if.valid && !smp_taken) begin
			// hold until accepted
		end else if (tx_gap > 0) begin
			tx_gap--;
			smp_if.valid <= 1'b0;
		end else if (pending_samples.size() == 0) begin
			smp_if.valid <= 1'b0;
		end else if (tx_idle_on && $urandom_range(0, 7) == 0) begin
			tx_gap = int'($urandom_range(1, 15)) - 1;
			smp_if.valid <= 1'b0;
		end else begin
			smp_if.data  <= pending_samples.pop_front();
			smp_if.valid <= 1'b1;
		end
	end

	// Result receiver: long hold-off on request, random stall bursts otherwise
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (arst_n !== 1'b1) begin
			res_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			res_if.ready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
			rx_gap = int'($urandom_range(1, 15)) - 1;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("watchdog expired after %0d cycles, %0d results outstanding",
				cycle_count, expected_readings.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic push_sample(input logic [15:0] v, input logic [15:0] c, input logic a);
		csem_pkg::sample_t s;
		s.voltage_cv     = v;
		s.current_ma     = c;
		s.session_active = a;
		pending_samples.push_back(s);
	endtask

	// Drain: nothing queued, nothing offered, nothing outstanding
	task automatic wait_idle();
		@(posedge clk);
		while (pending_samples.size() != 0 || smp_if.valid || expected_readings.size() != 0)
			@(posedge clk);
	endtask

	// One register write; dirty fills the bits above the register with noise
	task automatic cfg_write(input logic [csem_pkg::CFG_IDX_W-1:0] idx, input logic [47:0] value,
			input bit dirty);
		logic [47:0] word, keep;
		int          w;
		w = (idx == csem_pkg::CFG_WINDOW_LEN) ? 8 :
			(idx == csem_pkg::CFG_ENERGY_LIMIT) ? 48 : 16;
		word = value;
		if (dirty && w < 48) begin
			keep = (48'd1 << w) - 48'd1;
			word = (value & keep) | (48'({$urandom, $urandom}) & ~keep);
		end
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = word;
		case (idx)
			csem_pkg::CFG_CURRENT_FLOOR: reg_floor  = word[15:0];
			csem_pkg::CFG_LOW_VOLTAGE:   reg_low_v  = word[15:0];
			csem_pkg::CFG_OVER_CURRENT:  reg_over_i = word[15:0];
			csem_pkg::CFG_FULL_CURRENT:  reg_full_i = word[15:0];
			csem_pkg::CFG_WINDOW_LEN:    reg_window = word[7:0];
			csem_pkg::CFG_ENERGY_LIMIT:  reg_limit  = word[47:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Mostly well-formed charging samples that stay inside the current thresholds
	task automatic random_samples(input int n);
		logic [15:0] v, c, lo_c;
		lo_c = (reg_full_i == 0) ? 16'd0 : ((reg_full_i > reg_floor) ? reg_full_i : reg_floor);
		repeat (n) begin
			if ($urandom_range(0, 4) == 0) begin
				push_sample(16'($urandom), 16'($urandom), 1'b0);
			end else begin
				v = 16'($urandom_range(reg_low_v, 16'hFFFF));
				c = 16'($urandom_range(lo_c, reg_over_i));
				case ($urandom_range(0, 9))
					0: v = reg_low_v;
					1: c = lo_c;
					2: c = reg_over_i;
					default: ;
				endcase
				push_sample(v, c, 1'b1);
			end
		end
	endtask

	// New threshold set, then random traffic; flags must not trip here
	task automatic run_phase(input int k, input int n);
		logic [15:0] floor_v, low_v, over_v, full_v, lo_c;
		logic [7:0]  win_v;
		logic [47:0] lim_v;
		int          len, fill;
		floor_v = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 2000));
		win_v = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 16));
		full_v = 16'd0;
		if (win_v <= 16 && $urandom_range(0, 1) == 1)
			full_v = 16'($urandom_range(1, 3000));
		case (k)
			0: begin
				floor_v = 16'hFFFF;
				win_v = 8'd0;
			end
			1: begin
				floor_v = 16'd0;
				win_v = 8'hFF;
				full_v = 16'd0;
			end
			2: begin
				win_v = 8'd1;
				full_v = 16'($urandom_range(1, 3000));
			end
			default: ;
		endcase
		lo_c = (full_v == 0) ? 16'd0 : ((full_v > floor_v) ? full_v : floor_v);
		over_v = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'($urandom_range(lo_c, 16'hFFFF));
		low_v = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 40000));
		lim_v = ($urandom_range(0, 1) == 1) ? ENERGY_FULL_SCALE :
			energy_acc + 48'h100_0000_0000 + 48'($urandom);
		cfg_write(csem_pkg::CFG_FULL_CURRENT, 48'd0, 1'b1);
		cfg_write(csem_pkg::CFG_CURRENT_FLOOR, 48'(floor_v), 1'b1);
		cfg_write(csem_pkg::CFG_LOW_VOLTAGE, 48'(low_v), 1'b1);
		cfg_write(csem_pkg::CFG_OVER_CURRENT, 48'(over_v), 1'b1);
		cfg_write(csem_pkg::CFG_ENERGY_LIMIT, lim_v, 1'b1);
		cfg_write(csem_pkg::CFG_WINDOW_LEN, 48'(win_v), 1'b1);
		// close the open window before a nonzero full threshold can judge it
		if (full_v != 0) begin
			len = (win_v == 0) ? 1 : int'(win_v);
			fill = (int'(window_cnt) >= len) ? 1 : len - int'(window_cnt);
			repeat (fill)
				push_sample(16'($urandom_range(low_v, 16'hFFFF)),
					16'($urandom_range(0, over_v)), 1'b1);
			wait_idle();
			cfg_write(csem_pkg::CFG_FULL_CURRENT, 48'(full_v), 1'b1);
		end
		config_settings++;
		tx_idle_on = (k != 1);
		rx_idle_on = (k != 1);
		if (k == 3) begin
			tx_idle_on = 1'b0;
			hold_request = 150;
		end
		random_samples(n);
		wait_idle();
	endtask

	// Trip one monitor right at its threshold, then show the flags hold
	task automatic flag_trial();
		logic [15:0] v, c, thr, f;
		logic [31:0] p;
		int          fill;
		trial_kind = trial_t'($urandom_range(0, 4));
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		cfg_write(csem_pkg::CFG_FULL_CURRENT, 48'd0, 1'b0);
		cfg_write(csem_pkg::CFG_LOW_VOLTAGE, 48'd0, 1'b0);
		cfg_write(csem_pkg::CFG_OVER_CURRENT, 48'hFFFF, 1'b0);
		cfg_write(csem_pkg::CFG_CURRENT_FLOOR, 48'd0, 1'b0);
		cfg_write(csem_pkg::CFG_ENERGY_LIMIT, ENERGY_FULL_SCALE, 1'b0);
		config_settings++;
		case (trial_kind)
			TRIAL_FULL: begin
				cfg_write(csem_pkg::CFG_WINDOW_LEN, 48'd4, 1'b0);
				fill = (window_cnt >= 4) ? 1 : 4 - int'(window_cnt);
				repeat (fill)
					push_sample(16'($urandom), 16'($urandom), 1'b1);
				wait_idle();
				f = 16'($urandom_range(100, 10000));
				cfg_write(csem_pkg::CFG_FULL_CURRENT, 48'(f), 1'b0);
				// window sum exactly at the threshold: still charging
				push_sample(16'($urandom), f - 16'd1, 1'b1);
				push_sample(16'($urandom), f + 16'd1, 1'b1);
				push_sample(16'($urandom), f, 1'b1);
				push_sample(16'($urandom), f, 1'b1);
				// one milliamp short over the window: full
				push_sample(16'($urandom), f - 16'd1, 1'b1);
				push_sample(16'($urandom), f, 1'b1);
				push_sample(16'($urandom), f, 1'b1);
				push_sample(16'($urandom), f, 1'b1);
			end
			TRIAL_UNDERVOLT: begin
				thr = 16'($urandom_range(1, 16'hFFFF));
				cfg_write(csem_pkg::CFG_LOW_VOLTAGE, 48'(thr), 1'b0);
				push_sample(thr, 16'($urandom), 1'b1);
				push_sample(16'($urandom_range(thr, 16'hFFFF)), 16'($urandom), 1'b1);
				push_sample(thr - 16'd1, 16'($urandom), 1'b1);
			end
			TRIAL_OVERCURRENT: begin
				thr = 16'($urandom_range(0, 16'hFFFE));
				cfg_write(csem_pkg::CFG_OVER_CURRENT, 48'(thr), 1'b0);
				push_sample(16'($urandom), thr, 1'b1);
				push_sample(16'($urandom), thr + 16'd1, 1'b1);
			end
			TRIAL_LIMIT: begin
				v = 16'($urandom_range(1, 16'hFFFF));
				c = 16'($urandom_range(1, 16'hFFFF));
				p = 32'(v) * 32'(c);
				// first sample lands one power step below the limit, second exactly on it
				cfg_write(csem_pkg::CFG_ENERGY_LIMIT, energy_acc + 48'(p) * 48'd2, 1'b0);
				push_sample(v, c, 1'b1);
				push_sample(v, c, 1'b1);
			end
			default: begin
				cfg_write(csem_pkg::CFG_CURRENT_FLOOR, 48'd200, 1'b0);
				cfg_write(csem_pkg::CFG_ENERGY_LIMIT, 48'd0, 1'b0);
				push_sample(16'($urandom), 16'($urandom_range(0, 199)), 1'b1);
				push_sample(16'($urandom), 16'($urandom_range(200, 16'hFFFF)), 1'b1);
			end
		endcase
		repeat (12)
			push_sample(16'($urandom), 16'($urandom), $urandom_range(0, 3) != 0);
		wait_idle();
		// relax the thresholds: latched flags must still block updates
		cfg_write(csem_pkg::CFG_LOW_VOLTAGE, 48'd0, 1'b0);
		cfg_write(csem_pkg::CFG_OVER_CURRENT, 48'hFFFF, 1'b0);
		cfg_write(csem_pkg::CFG_ENERGY_LIMIT, ENERGY_FULL_SCALE, 1'b0);
		repeat (12)
			push_sample(16'($urandom), 16'($urandom), $urandom_range(0, 3) != 0);
		wait_idle();
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = '0;
		cfg_wdata    = '0;
		smp_if.valid = 1'b0;
		smp_if.data  = '0;
		res_if.ready = 1'b0;
		tx_idle_on   = 1'b1;
		rx_idle_on   = 1'b1;
		reg_floor    = csem_pkg::RST_CURRENT_FLOOR;
		reg_low_v    = csem_pkg::RST_LOW_VOLTAGE;
		reg_over_i   = csem_pkg::RST_OVER_CURRENT;
		reg_full_i   = csem_pkg::RST_FULL_CURRENT;
		reg_window   = csem_pkg::RST_WINDOW_LEN;
		reg_limit    = csem_pkg::RST_ENERGY_LIMIT;
		energy_acc   = '0;
		window_sum   = '0;
		window_cnt   = '0;
		overload_q   = 1'b0;
		full_q       = 1'b0;
		timeout_q    = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset thresholds: idle samples at the field extremes, and counted zero-power ones
		push_sample(16'h0000, 16'h0000, 1'b0);
		push_sample(16'hFFFF, 16'hFFFF, 1'b0);
		push_sample(16'hFFFF, 16'd149, 1'b0);
		push_sample(16'hFFFF, 16'd150, 1'b0);
		push_sample(16'h0001, 16'hFFFF, 1'b0);
		push_sample(16'hAAAA, 16'h5555, 1'b0);
		push_sample(16'h5555, 16'hAAAA, 1'b0);
		push_sample(16'd18000, 16'd149, 1'b1);
		push_sample(16'hFFFF, 16'h0000, 1'b1);
		push_sample(16'hFFFF, 16'd149, 1'b1);
		wait_idle();
		config_settings++;

		// Writes to unused indexes are dropped; window shortened below its fill
		cfg_write(SPARE_IDX_LO, 48'({$urandom, $urandom}), 1'b0);
		cfg_write(SPARE_IDX_HI, 48'({$urandom, $urandom}), 1'b0);
		cfg_write(csem_pkg::CFG_FULL_CURRENT, 48'd0, 1'b0);
		cfg_write(csem_pkg::CFG_LOW_VOLTAGE, 48'd0, 1'b0);
		cfg_write(csem_pkg::CFG_OVER_CURRENT, 48'hFFFF, 1'b0);
		cfg_write(csem_pkg::CFG_CURRENT_FLOOR, 48'd0, 1'b0);
		cfg_write(csem_pkg::CFG_ENERGY_LIMIT, ENERGY_FULL_SCALE, 1'b0);
		cfg_write(csem_pkg::CFG_WINDOW_LEN, 48'd2, 1'b0);
		config_settings++;
		push_sample(16'hFFFF, 16'hFFFF, 1'b1);
		push_sample(16'h0000, 16'hFFFF, 1'b1);
		push_sample(16'h0001, 16'h0001, 1'b1);
		push_sample(16'hFFFF, 16'h0000, 1'b1);
		push_sample(16'h8000, 16'h7FFF, 1'b1);
		push_sample(16'h5555, 16'hAAAA, 1'b1);
		push_sample(16'h0000, 16'h0000, 1'b0);
		wait_idle();

		// Highest floor: everything but full scale current clips
		cfg_write(csem_pkg::CFG_CURRENT_FLOOR, 48'hFFFF, 1'b0);
		config_settings++;
		push_sample(16'd1000, 16'hFFFE, 1'b1);
		push_sample(16'd1000, 16'hFFFF, 1'b1);
		wait_idle();

		for (int k = 0; k < 7; k++)
			run_phase(k, 68);

		flag_trial();

		repeat (8) @(posedge clk);
		$display("Run metered %0d samples under %0d threshold settings, %0d results checked.",
			samples_metered, config_settings, readings_checked);
		$display("%0d samples counted toward energy; closing trial tripped %s; %0d mismatches.",
			counted_readings, trial_kind.name(), mismatch_count);
		if (mismatch_count == 0 && expected_readings.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
